// ----- src/assert_macros.svh -----
// assertion macros for the accumulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ----- src/wdva_pkg.sv -----
// constants and helpers for the wall deposition velocity accumulator
`default_nettype none
package wdva_pkg;
   localparam int FRACTION_BITS = 16;
   localparam int RELAX_FRAC    = 16;
   localparam int SUM_W         = 48;
   localparam int AREA_SUM_W    = 35;
   localparam int PROD_W        = 80;
   localparam int MUL_STEPS     = 32;
   localparam int DIV_W         = SUM_W + FRACTION_BITS;
   localparam int CNT_W         = $clog2(DIV_W);
   localparam logic [63:0] PI_Q32 = 64'h3_243F_6A89;
   localparam logic [63:0] PI_Q64 =
      (PI_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
   localparam logic [31:0] PI_Q = PI_Q64[31:0];

   localparam logic [2:0] REG_AREA_YZ  = 3'd0;
   localparam logic [2:0] REG_AREA_XZ  = 3'd1;
   localparam logic [2:0] REG_AREA_XY  = 3'd2;
   localparam logic [2:0] REG_RELAX    = 3'd3;
   localparam logic [2:0] REG_FIXED_RHO = 3'd4;

   typedef logic [SUM_W-1:0] sum_type;

   // floor(p >> F) clamped to 48 bits
   function automatic sum_type sat_prod(input logic [PROD_W-1:0] p);
      logic [PROD_W-1:0] s;
      s = p >> FRACTION_BITS;
      return (|s[PROD_W-1:SUM_W]) ? '1 : s[SUM_W-1:0];
   endfunction

   function automatic logic [31:0] sat_quot(input logic [DIV_W-1:0] q);
      return (|q[DIV_W-1:32]) ? '1 : q[31:0];
   endfunction

   function automatic sum_type add_sat48(input sum_type a, input sum_type b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- src/wall_deposition_velocity_accumulator.sv -----
// per-cell wall deposition velocity accumulator with bit-serial divide and multiply
// a contributing face runs a divide (skipped at zero density) and five Q16.16 multiplies;
//   a non-contributing face runs neither; the last face then adds a divide (skipped
// when the area sum is zero) and a multiply, neither when no face counted
// one item at a time; the shared restoring divider and shift-add multiplier set the rate
// synchronous active-high reset clears the sums and the result valid flag and loads the csr defaults
`default_nettype none
`include "assert_macros.svh"
module wall_deposition_velocity_accumulator (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [95:0] req_tdata,  // face_flux, neighbor_density, particle_diameter
   input  wire  logic [4:0]  req_tuser,  // cell_is_solid, face_index, neighbor_is_flow
   input  wire  logic        req_tlast,  // last_face
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [95:0]       rsp_tdata,  // velocity_increment, diameter_numerator,
                                         // diameter_denominator
   output logic [0:0]        rsp_tuser,  // cell_active
   input  wire  logic        csr_valid,
   output logic              csr_ready,
   input  wire  logic [2:0]  csr_index,
   input  wire  logic [31:0] csr_wdata
);
   import wdva_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DRATE = 4'd1;
   localparam logic [3:0] S_MWR   = 4'd2;
   localparam logic [3:0] S_MD2   = 4'd3;
   localparam logic [3:0] S_MPA   = 4'd4;
   localparam logic [3:0] S_MSQ   = 4'd5;
   localparam logic [3:0] S_MCU   = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;
   localparam logic [3:0] S_DAVG  = 4'd8;
   localparam logic [3:0] S_MVEL  = 4'd9;
   localparam logic [3:0] S_EMIT  = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [31:0] area_yz_ff, area_yz_in, area_xz_ff, area_xz_in, area_xy_ff, area_xy_in;
   logic [16:0] relax_ff, relax_in;
   logic [31:0] fixed_rho_ff, fixed_rho_in;
   sum_type     wrs_ff, wrs_in, cub_ff, cub_in, sqr_ff, sqr_in;
   logic [AREA_SUM_W-1:0] eas_ff, eas_in;
   logic        any_ff, any_in;
   logic [31:0] d_ff, d_in, area_ff, area_in, rate_ff, rate_in, vel_ff, vel_in;
   logic        last_ff, last_in;
   logic [PROD_W-1:0] ma_ff, ma_in, acc_ff, acc_in;
   logic [31:0] mb_ff, mb_in;
   logic [DIV_W-1:0] dq_ff, dq_in;
   logic [AREA_SUM_W-1:0] rem_ff, rem_in, dv_ff, dv_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic        rsp_active_ff, rsp_active_in;

   logic        ld_mul, ld_div, mul_run, div_run, mul_last, div_last, contrib;
   logic [SUM_W-1:0] ld_a;
   logic [31:0] ld_b, mag, rho, area_sel, zrate, avg0;
   logic [DIV_W-1:0] ld_dvd, dq_next;
   logic [AREA_SUM_W-1:0] ld_dv;
   logic [PROD_W-1:0] acc_sum, vel_shift;
   sum_type     prod_sat;
   logic [AREA_SUM_W:0] trial, eas_sum;
   logic        ge;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_active_ff;

   always_comb begin
      state_in = state_ff;
      area_yz_in = area_yz_ff; area_xz_in = area_xz_ff; area_xy_in = area_xy_ff;
      relax_in = relax_ff; fixed_rho_in = fixed_rho_ff;
      wrs_in = wrs_ff; eas_in = eas_ff; cub_in = cub_ff; sqr_in = sqr_ff; any_in = any_ff;
      d_in = d_ff; area_in = area_ff; rate_in = rate_ff; vel_in = vel_ff; last_in = last_ff;
      ma_in = ma_ff; mb_in = mb_ff; acc_in = acc_ff;
      dq_in = dq_ff; rem_in = rem_ff; dv_in = dv_ff; cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff; rsp_active_in = rsp_active_ff;
      ld_mul = 1'b0; ld_a = '0; ld_b = '0;
      ld_div = 1'b0; ld_dvd = '0; ld_dv = '0;

      mul_run = (state_ff == S_MWR) || (state_ff == S_MD2) || (state_ff == S_MPA) ||
                (state_ff == S_MSQ) || (state_ff == S_MCU) || (state_ff == S_MVEL);
      div_run = (state_ff == S_DRATE) || (state_ff == S_DAVG);
      mul_last = (cnt_ff == CNT_W'(MUL_STEPS - 1));
      div_last = (cnt_ff == CNT_W'(DIV_W - 1));

      acc_sum  = acc_ff + (mb_ff[0] ? ma_ff : '0);
      prod_sat = sat_prod(acc_sum);
      vel_shift = acc_sum >> RELAX_FRAC;
      trial   = {rem_ff, dq_ff[DIV_W-1]};
      ge      = (trial >= {1'b0, dv_ff});
      dq_next = {dq_ff[DIV_W-2:0], ge};

      contrib  = req_tuser[0] && req_tuser[4] && (req_tuser[3:1] <= 3'd5);
      mag      = req_tdata[31] ? (~req_tdata[31:0] + 32'd1) : req_tdata[31:0];
      rho      = (fixed_rho_ff != '0) ? fixed_rho_ff : req_tdata[63:32];
      zrate    = (mag != '0) ? '1 : '0;
      area_sel = (req_tuser[3:1] < 3'd2) ? area_yz_ff :
                 ((req_tuser[3:1] < 3'd4) ? area_xz_ff : area_xy_ff);
      eas_sum  = {1'b0, eas_ff} + (AREA_SUM_W + 1)'(area_ff);
      avg0     = (wrs_ff != '0) ? '1 : '0;

      if (mul_run) begin
         acc_in = acc_sum;
         ma_in  = ma_ff << 1;
         mb_in  = mb_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
      end
      if (div_run) begin
         rem_in = ge ? AREA_SUM_W'(trial - {1'b0, dv_ff}) : trial[AREA_SUM_W-1:0];
         dq_in  = dq_next;
         cnt_in = cnt_ff + 1'b1;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               d_in    = req_tdata[95:64];
               area_in = area_sel;
               last_in = req_tlast;
               if (contrib) begin
                  if (rho == '0) begin
                     rate_in = zrate;
                     ld_mul = 1'b1; ld_a = SUM_W'(zrate); ld_b = area_sel;
                     state_in = S_MWR;
                  end else begin
                     ld_div = 1'b1; ld_dvd = DIV_W'(mag) << FRACTION_BITS;
                     ld_dv = AREA_SUM_W'(rho);
                     state_in = S_DRATE;
                  end
               end else if (req_tlast) begin
                  state_in = S_FIN;
               end
            end
         end
         S_DRATE: begin
            if (div_last) begin
               rate_in = sat_quot(dq_next);
               ld_mul = 1'b1; ld_a = SUM_W'(sat_quot(dq_next)); ld_b = area_ff;
               state_in = S_MWR;
            end
         end
         S_MWR: begin
            if (mul_last) begin
               wrs_in = add_sat48(wrs_ff, prod_sat);
               eas_in = eas_sum[AREA_SUM_W] ? '1 : eas_sum[AREA_SUM_W-1:0];
               ld_mul = 1'b1; ld_a = SUM_W'(d_ff); ld_b = d_ff;
               state_in = S_MD2;
            end
         end
         S_MD2: begin
            if (mul_last) begin
               ld_mul = 1'b1; ld_a = prod_sat; ld_b = PI_Q;
               state_in = S_MPA;
            end
         end
         S_MPA: begin
            if (mul_last) begin
               ld_mul = 1'b1; ld_a = prod_sat; ld_b = rate_ff;
               state_in = S_MSQ;
            end
         end
         S_MSQ: begin
            if (mul_last) begin
               sqr_in = add_sat48(sqr_ff, prod_sat);
               ld_mul = 1'b1; ld_a = prod_sat; ld_b = d_ff;
               state_in = S_MCU;
            end
         end
         S_MCU: begin
            if (mul_last) begin
               cub_in = add_sat48(cub_ff, prod_sat);
               any_in = 1'b1;
               state_in = last_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            if (!any_ff) begin
               vel_in = '0;
               state_in = S_EMIT;
            end else if (eas_ff == '0) begin
               ld_mul = 1'b1; ld_a = SUM_W'(avg0); ld_b = 32'(relax_ff);
               state_in = S_MVEL;
            end else begin
               ld_div = 1'b1; ld_dvd = DIV_W'(wrs_ff) << FRACTION_BITS; ld_dv = eas_ff;
               state_in = S_DAVG;
            end
         end
         S_DAVG: begin
            if (div_last) begin
               ld_mul = 1'b1; ld_a = SUM_W'(sat_quot(dq_next)); ld_b = 32'(relax_ff);
               state_in = S_MVEL;
            end
         end
         S_MVEL: begin
            if (mul_last) begin
               vel_in = (|vel_shift[PROD_W-1:32]) ? '1 : vel_shift[31:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_active_in = any_ff;
               rsp_data_in   = {((|sqr_ff[SUM_W-1:32]) ? 32'hFFFF_FFFF : sqr_ff[31:0]),
                                ((|cub_ff[SUM_W-1:32]) ? 32'hFFFF_FFFF : cub_ff[31:0]),
                                vel_ff};
               wrs_in = '0; eas_in = '0; cub_in = '0; sqr_in = '0; any_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (ld_mul) begin
         ma_in = PROD_W'(ld_a); mb_in = ld_b; acc_in = '0; cnt_in = '0;
      end
      if (ld_div) begin
         dq_in = ld_dvd; dv_in = ld_dv; rem_in = '0; cnt_in = '0;
      end

      if (csr_valid) begin
         case (csr_index)
            REG_AREA_YZ:   area_yz_in = csr_wdata;
            REG_AREA_XZ:   area_xz_in = csr_wdata;
            REG_AREA_XY:   area_xy_in = csr_wdata;
            REG_RELAX:     relax_in = csr_wdata[16:0];
            REG_FIXED_RHO: fixed_rho_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         area_yz_ff <= 32'd65536; area_xz_ff <= 32'd65536; area_xy_ff <= 32'd65536;
         relax_ff <= 17'd3277; fixed_rho_ff <= '0;
         wrs_ff <= '0; eas_ff <= '0; cub_ff <= '0; sqr_ff <= '0; any_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         area_yz_ff <= area_yz_in; area_xz_ff <= area_xz_in; area_xy_ff <= area_xy_in;
         relax_ff <= relax_in; fixed_rho_ff <= fixed_rho_in;
         wrs_ff <= wrs_in; eas_ff <= eas_in; cub_ff <= cub_in; sqr_ff <= sqr_in;
         any_ff <= any_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
      end
      d_ff <= d_in; area_ff <= area_in; rate_ff <= rate_in; vel_ff <= vel_in;
      last_ff <= last_in;
      ma_ff <= ma_in; mb_ff <= mb_in; acc_ff <= acc_in;
      dq_ff <= dq_in; rem_ff <= rem_in; dv_ff <= dv_in;
      rsp_data_ff <= rsp_data_in; rsp_active_ff <= rsp_active_in;
   end

   `CHK_IMPLY(a_idle_clear, clock, reset, state_ff == S_IDLE && !any_ff, wrs_ff == '0 && eas_ff == '0 && cub_ff == '0 && sqr_ff == '0, "sums not clear while no face counted")
   `CHK_NEXT(a_face_marks, clock, reset, state_ff == S_MCU && mul_last, any_ff, "contributing face not marked")
   `CHK_IMPLY(a_mul_bound, clock, reset, mul_run, cnt_ff < CNT_W'(MUL_STEPS), "multiplier ran past its width")
   `CHK_IMPLY(a_inactive_zero, clock, reset, rsp_valid_ff && !rsp_active_ff, rsp_data_ff == '0, "inactive cell result not zero")
endmodule
`default_nettype wire

// ----- verif/wall_deposition_velocity_accumulator_tb.sv -----
// testbench for the wall deposition velocity accumulator: directed and random faces
`timescale 1ns / 1ps
module wall_deposition_velocity_accumulator_tb;
   import wdva_pkg::*;

   typedef struct packed {
      logic        active;
      logic [31:0] velocity;
      logic [31:0] numerator;
      logic [31:0] denominator;
   } cell_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;  // face_flux, neighbor_density, particle_diameter
   logic [4:0]  req_tuser = '0;  // cell_is_solid, face_index, neighbor_is_flow
   logic        req_tlast = 1'b0;  // last_face
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;  // velocity_increment, diameter_numerator, diameter_denominator
   logic [0:0]  rsp_tuser;  // cell_active
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor copy of registers and sums
   logic [31:0] face_area [3];
   logic [16:0] relax_coef;
   logic [31:0] user_density;
   logic [47:0] rate_area_sum, cube_sum, square_sum;
   logic [34:0] area_sum;
   logic        any_contrib;

   cell_result_type pending_cells[$];
   int errors = 0;
   bit no_idle = 1'b0;

   wall_deposition_velocity_accumulator dut (.*);

   always #10 clock = ~clock;

   initial begin
      #100_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int gap_len();
      if (no_idle) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic logic [47:0] mul_q(input logic [47:0] a, input logic [31:0] b);
      logic [79:0] p;
      p = ({32'd0, a} * {48'd0, b}) >> FRACTION_BITS;
      return (|p[79:48]) ? '1 : p[47:0];
   endfunction

   function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? '1 : s[47:0];
   endfunction

   function automatic logic [31:0] clamp32(input logic [63:0] v);
      return (|v[63:32]) ? '1 : v[31:0];
   endfunction

   // updates the cell sums; returns 1 with the expected result on the last face
   function automatic bit accumulate_face(input logic [4:0] user, input logic [95:0] data,
                                          input logic last, output cell_result_type res);
      logic [63:0] mag, rho, rate, avg, asum;
      logic [47:0] sq, parea;
      logic [35:0] s36;
      logic [2:0]  face;
      face = user[3:1];
      res = '0;
      if (user[0] && user[4] && face <= 3'd5) begin
         mag = data[31] ? {32'd0, -data[31:0]} : {32'd0, data[31:0]};
         rho = user_density != 0 ? {32'd0, user_density} : {32'd0, data[63:32]};
         if (rho == 0) rate = mag != 0 ? 64'hFFFF_FFFF : 0;
         else rate = clamp32((mag << FRACTION_BITS) / rho);
         rate_area_sum = add48(rate_area_sum, mul_q(rate[47:0], face_area[face >> 1]));
         s36 = {1'b0, area_sum} + {4'd0, face_area[face >> 1]};
         area_sum = s36[35] ? '1 : s36[34:0];
         parea = mul_q(mul_q({16'd0, data[95:64]}, data[95:64]), PI_Q);
         sq = mul_q(parea, rate[31:0]);
         square_sum = add48(square_sum, sq);
         cube_sum = add48(cube_sum, mul_q(sq, data[95:64]));
         any_contrib = 1'b1;
      end
      if (!last) return 1'b0;
      if (any_contrib) begin
         asum = {29'd0, area_sum};
         if (asum == 0) avg = rate_area_sum != 0 ? 64'hFFFF_FFFF : 0;
         else avg = clamp32(({16'd0, rate_area_sum} << FRACTION_BITS) / asum);
         res.active = 1'b1;
         res.velocity = clamp32((avg * {47'd0, relax_coef}) >> 16);
         res.numerator = clamp32({16'd0, cube_sum});
         res.denominator = clamp32({16'd0, square_sum});
      end
      rate_area_sum = '0;
      area_sum = '0;
      cube_sum = '0;
      square_sum = '0;
      any_contrib = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_face(input bit solid, input logic [2:0] face, input bit flow,
                            input logic [31:0] flux, input logic [31:0] nrho,
                            input logic [31:0] diam, input bit last);
      int gap;
      cell_result_type res;
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {diam, nrho, flux};
      req_tuser <= {flow, face, solid};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (accumulate_face({flow, face, solid}, {diam, nrho, flux}, last, res))
         pending_cells = {pending_cells, res};
   endtask

   // lets all outstanding work finish so the block is idle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_AREA_YZ:   face_area[0] = value;
         REG_AREA_XZ:   face_area[1] = value;
         REG_AREA_XY:   face_area[2] = value;
         REG_RELAX:     relax_coef = value[16:0];
         REG_FIXED_RHO: user_density = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(input logic [31:0] ayz, input logic [31:0] axz,
                            input logic [31:0] axy, input logic [16:0] relax,
                            input logic [31:0] rho);
      write_reg(REG_AREA_YZ, ayz);
      write_reg(REG_AREA_XZ, axz);
      write_reg(REG_AREA_XY, axy);
      write_reg(REG_RELAX, {15'd0, relax});
      write_reg(REG_FIXED_RHO, rho);
   endtask

   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 3) << 16 | $urandom_range(0, 65535);
         2: return $urandom_range(0, 255);
         default: return $urandom_range(1 << 12, 1 << 18);
      endcase
   endfunction

   // mostly well-formed cells, some noise faces
   task automatic random_cell();
      int nfaces;
      bit noise;
      logic [31:0] diam;
      nfaces = $urandom_range(1, 6);
      diam = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 1 << 17);
      for (int i = 0; i < nfaces; i++) begin
         noise = $urandom_range(0, 9) == 0;
         send_face(noise ? $urandom_range(0, 1) : 1'b1,
                   noise ? $urandom_range(0, 7) : $urandom_range(0, 5),
                   noise ? $urandom_range(0, 1) : ($urandom_range(0, 7) != 0),
                   $urandom_range(0, 3) == 0 ? $urandom() : rand_q(),
                   $urandom_range(0, 15) == 0 ? 32'd0 : rand_q(), diam, i == nfaces - 1);
      end
   endtask

   task automatic test_directed();
      // extremes of flux, density and diameter
      send_face(1, 0, 1, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 0);
      send_face(1, 1, 1, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1);
      send_face(1, 2, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1);
      // zero density with and without flux
      send_face(1, 3, 1, 32'h0000_1000, 32'd0, 32'h0000_8000, 0);
      send_face(1, 4, 1, 32'd0, 32'd0, 32'h0000_8000, 1);
      // non-contributing faces, alone and mixed in
      send_face(0, 5, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1);
      send_face(1, 6, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
      send_face(1, 7, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1);
      send_face(1, 5, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
      send_face(1, 5, 1, 32'hFFFE_0000, 32'h0000_8000, 32'h0000_4000, 1);
      for (int f = 0; f < 6; f++)
         send_face(1, f, 1, 32'h0002_0000 + f, 32'h0001_0000, 32'h0000_2000, f == 5);
      drain();
   endtask

   task automatic test_config_extremes();
      // zero areas exercise the empty area sum, fixed density overrides neighbors
      write_all(32'd0, 32'd0, 32'd0, 17'd65536, 32'd0);
      send_face(1, 0, 1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1);
      send_face(1, 2, 1, 32'd0, 32'h0001_0000, 32'h0001_0000, 1);
      drain();
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, 32'hFFFF_FFFF);
      for (int f = 0; f < 6; f++)
         send_face(1, f, 1, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, f == 5);
      drain();
      write_all(32'h0000_0001, 32'h0002_0000, 32'h0000_4000, 17'd65536, 32'd1);
      repeat (20) random_cell();
      drain();
   endtask

   task automatic test_random(input int ncells);
      for (int phase = 0; phase < 4; phase++) begin
         write_all(rand_q(), rand_q(), rand_q(), $urandom_range(0, 65536),
                   $urandom_range(0, 1) ? 32'd0 : rand_q());
         no_idle = phase == 2;
         for (int c = 0; c < ncells; c++) random_cell();
         no_idle = 1'b0;
         drain();
      end
   endtask

   // receiver side stalls
   always @(negedge clock) begin
      if (reset || no_idle) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 2) != 0) && ($urandom_range(0, 39) != 0);
   end

   always @(posedge clock) begin
      cell_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64]};
         if (pending_cells.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = pending_cells.pop_front();
            if (got.active !== want.active)
               $display("%0t: cell_active exp %h got %h", $time, want.active, got.active);
            if (got.velocity !== want.velocity)
               $display("%0t: velocity exp %h got %h", $time, want.velocity, got.velocity);
            if (got.numerator !== want.numerator)
               $display("%0t: numerator exp %h got %h", $time, want.numerator,
                        got.numerator);
            if (got.denominator !== want.denominator)
               $display("%0t: denominator exp %h got %h", $time, want.denominator,
                        got.denominator);
            if (got !== want) errors++;
         end
      end
   end

   initial begin
      face_area[0] = 32'd65536;
      face_area[1] = 32'd65536;
      face_area[2] = 32'd65536;
      relax_coef = 17'd3277;
      user_density = '0;
      rate_area_sum = '0;
      area_sum = '0;
      cube_sum = '0;
      square_sum = '0;
      any_contrib = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_random(120);
      drain();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
